// ----- rtl/core/eaf_pkg.sv -----
// Shared types and constants for the exception archive filter.
`timescale 1ns / 1ps
package eaf_pkg;

  localparam int unsigned QUAL_W    = 8;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned TIME_W    = 63;
  localparam int unsigned THR_W     = 31;
  localparam int unsigned MASK_W    = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam int unsigned ADV_W     = VALUE_W + 1;
  localparam int unsigned MICROS_W  = 20;
  localparam int unsigned NUM_W     = ADV_W + MICROS_W;
  localparam int unsigned DT_W      = NUM_W;
  localparam int unsigned DT_LO_W   = 27;
  localparam int unsigned DT_HI_W   = DT_W - DT_LO_W;
  localparam int unsigned P_LO_W    = DT_LO_W + THR_W;
  localparam int unsigned P_HI_W    = DT_HI_W + THR_W;
  localparam int unsigned PROD_W    = DT_W + THR_W;

  localparam logic [MICROS_W-1:0] MICROS_PER_SECOND = 20'd1000000;

  localparam logic [1:0] QUAL_CLASS_GOOD = 2'b11;
  localparam logic [1:0] QUAL_CLASS_BAD  = 2'b00;

  localparam int unsigned EN_QUAL_CHANGE = 0;
  localparam int unsigned EN_BAD         = 1;
  localparam int unsigned EN_RETURN_GOOD = 2;
  localparam int unsigned EN_STEP        = 3;
  localparam int unsigned EN_RATE        = 4;
  localparam int unsigned EN_LIMIT       = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROC_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_HIGH  = 3'd4;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_QUALITY = 3'd1,
    KIND_STEP    = 3'd2,
    KIND_RATE    = 3'd3,
    KIND_LIMIT   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [MASK_W-1:0]         enable_mask;
    logic [THR_W-1:0]          step_min;
    logic [THR_W-1:0]          roc_max;
    logic signed [VALUE_W-1:0] value_low_limit;
    logic signed [VALUE_W-1:0] value_high_limit;
  } cfg_t;

  typedef struct packed {
    logic             first;
    logic             qual_hit;
    logic             step_hit;
    logic             limit_hit;
    logic             rate_en;
    logic             dt_big;
    logic [ADV_W-1:0] adv;
    logic [DT_W-1:0]  dt;
  } entry_t;

  typedef struct packed {
    logic              first;
    logic              qual_hit;
    logic              step_hit;
    logic              limit_hit;
    logic              rate_en;
    logic              dt_big;
    logic              rl_zero;
    logic [NUM_W-1:0]  num;
    logic [P_LO_W-1:0] p_lo;
    logic [P_HI_W-1:0] p_hi;
  } prod_stage_t;

  typedef struct packed {
    logic              first;
    logic              qual_hit;
    logic              step_hit;
    logic              limit_hit;
    logic              rate_en;
    logic              dt_big;
    logic              rl_zero;
    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] prod;
  } sum_stage_t;

endpackage

// ----- rtl/core/eaf_front.sv -----
// Front end: accepts samples, tracks previous sample, classifies the cheap checks.
`timescale 1ns / 1ps
module eaf_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  eaf_pkg::cfg_t                        cfg,
  input  logic                                 in_valid,
  input  logic                                 full,
  input  logic [eaf_pkg::QUAL_W-1:0]           in_sample_quality,
  input  logic signed [eaf_pkg::VALUE_W-1:0]   in_sample_value,
  input  logic [eaf_pkg::TIME_W-1:0]           in_sample_time_us,
  output logic                                 push,
  output eaf_pkg::entry_t                      entry
);
  import eaf_pkg::*;

  logic                       seen_first_r, seen_first_nxt;
  logic [QUAL_W-1:0]          last_quality_r;
  logic signed [VALUE_W-1:0]  last_value_r;
  logic [TIME_W-1:0]          last_time_r;

  logic signed [ADV_W-1:0]    dv;
  logic [ADV_W-1:0]           adv;
  logic [TIME_W-1:0]          dt_full;
  logic                       dt_pos;
  logic                       q_change, q_bad, q_ret_good;

  assign push = in_valid && !full;

  always_comb begin
    dv      = $signed({in_sample_value[VALUE_W-1], in_sample_value})
            - $signed({last_value_r[VALUE_W-1], last_value_r});
    adv     = dv[ADV_W-1] ? (~dv + 1'b1) : dv;
    dt_full = in_sample_time_us - last_time_r;
    dt_pos  = in_sample_time_us > last_time_r;

    q_change   = cfg.enable_mask[EN_QUAL_CHANGE] && (in_sample_quality != last_quality_r);
    q_bad      = cfg.enable_mask[EN_BAD]
              && (in_sample_quality[QUAL_W-1 -: 2] == QUAL_CLASS_BAD);
    q_ret_good = cfg.enable_mask[EN_RETURN_GOOD]
              && (in_sample_quality[QUAL_W-1 -: 2] == QUAL_CLASS_GOOD)
              && (last_quality_r[QUAL_W-1 -: 2] != QUAL_CLASS_GOOD);

    entry.first     = !seen_first_r;
    entry.qual_hit  = q_change || q_bad || q_ret_good;
    entry.step_hit  = cfg.enable_mask[EN_STEP] && (adv >= {2'b00, cfg.step_min});
    entry.limit_hit = cfg.enable_mask[EN_LIMIT]
                   && ((in_sample_value < cfg.value_low_limit)
                    || (in_sample_value > cfg.value_high_limit));
    entry.rate_en   = cfg.enable_mask[EN_RATE] && dt_pos;
    entry.dt_big    = |dt_full[TIME_W-1:DT_W];
    entry.adv       = adv;
    entry.dt        = dt_full[DT_W-1:0];

    seen_first_nxt  = seen_first_r || push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_first_r   <= 1'b0;
      last_quality_r <= '0;
      last_value_r   <= '0;
      last_time_r    <= '0;
    end else begin
      seen_first_r <= seen_first_nxt;
      if (push) begin
        last_quality_r <= in_sample_quality;
        last_value_r   <= in_sample_value;
        last_time_r    <= in_sample_time_us;
      end
    end
  end

endmodule

// ----- rtl/core/eaf_queue.sv -----
// Short queue of classified beats between the front and back ends.
`timescale 1ns / 1ps
module eaf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  eaf_pkg::entry_t  wr_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output eaf_pkg::entry_t  head
);
  import eaf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t            mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ----- rtl/core/eaf_back.sv -----
// Back end: rate-of-change multiply pipeline, priority resolve and output register.
`timescale 1ns / 1ps
module eaf_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [eaf_pkg::THR_W-1:0]    roc_max,
  input  logic                         head_valid,
  input  eaf_pkg::entry_t              head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_archive_now,
  output logic [2:0]                   out_exception_kind
);
  import eaf_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  prod_stage_t  s1_r, s1_nxt;
  logic         s2_valid_r, s2_valid_nxt;
  sum_stage_t   s2_r, s2_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         archive_r, archive_nxt;
  kind_t        kind_r, kind_nxt;

  logic         out_free, s2_free, s1_free;
  logic         s1_load, s2_load, out_load;
  logic         rate_hit;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign pop      = head_valid && s1_free;
  assign s1_load  = pop;
  assign s2_load  = s1_valid_r && s2_free;
  assign out_load = s2_valid_r && out_free;

  always_comb begin
    s1_nxt.first     = head.first;
    s1_nxt.qual_hit  = head.qual_hit;
    s1_nxt.step_hit  = head.step_hit;
    s1_nxt.limit_hit = head.limit_hit;
    s1_nxt.rate_en   = head.rate_en;
    s1_nxt.dt_big    = head.dt_big;
    s1_nxt.rl_zero   = (roc_max == '0);
    s1_nxt.num       = head.adv * MICROS_PER_SECOND;
    s1_nxt.p_lo      = head.dt[DT_LO_W-1:0] * roc_max;
    s1_nxt.p_hi      = head.dt[DT_W-1:DT_LO_W] * roc_max;

    s2_nxt.first     = s1_r.first;
    s2_nxt.qual_hit  = s1_r.qual_hit;
    s2_nxt.step_hit  = s1_r.step_hit;
    s2_nxt.limit_hit = s1_r.limit_hit;
    s2_nxt.rate_en   = s1_r.rate_en;
    s2_nxt.dt_big    = s1_r.dt_big;
    s2_nxt.rl_zero   = s1_r.rl_zero;
    s2_nxt.num       = s1_r.num;
    s2_nxt.prod      = {s1_r.p_hi, {DT_LO_W{1'b0}}}
                     + {{(PROD_W-P_LO_W){1'b0}}, s1_r.p_lo};

    rate_hit = s2_r.rate_en
            && (s2_r.dt_big ? s2_r.rl_zero
                            : (s2_r.prod <= {{(PROD_W-NUM_W){1'b0}}, s2_r.num}));

    if (s2_r.first) begin
      kind_nxt = KIND_NONE;
    end else if (s2_r.qual_hit) begin
      kind_nxt = KIND_QUALITY;
    end else if (s2_r.step_hit) begin
      kind_nxt = KIND_STEP;
    end else if (rate_hit) begin
      kind_nxt = KIND_RATE;
    end else if (s2_r.limit_hit) begin
      kind_nxt = KIND_LIMIT;
    end else begin
      kind_nxt = KIND_NONE;
    end
    archive_nxt = s2_r.first || (kind_nxt != KIND_NONE);

    s1_valid_nxt  = s1_load || (s1_valid_r && !s2_free);
    s2_valid_nxt  = s2_load || (s2_valid_r && !out_free);
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= s1_nxt;
    end
    if (s2_load) begin
      s2_r <= s2_nxt;
    end
    if (out_load) begin
      archive_r <= archive_nxt;
      kind_r    <= kind_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_archive_now    = archive_r;
  assign out_exception_kind = kind_r;

endmodule

// ----- rtl/core/exception_archive_filter.sv -----
// Top level: configuration registers, front end, beat queue and back end.
// A taken sample beat passes through the queue, the two back-end stages and the output register.
// Throughput: one sample per cycle while in_stall is low; the rate multiply is split over two back-end stages.
// in_stall rises only when the QUEUE_DEPTH-entry queue between front and back is full.
// Reset (synchronous, rst_n low) clears the registers, previous-sample state and queue.
`timescale 1ns / 1ps
module exception_archive_filter #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [eaf_pkg::QUAL_W-1:0]          in_sample_quality,
  input  logic signed [eaf_pkg::VALUE_W-1:0]  in_sample_value,
  input  logic [eaf_pkg::TIME_W-1:0]          in_sample_time_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_archive_now,
  output logic [2:0]                          out_exception_kind,
  input  logic                                cfg_we,
  input  logic [eaf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [eaf_pkg::CFG_DAT_W-1:0]       cfg_wdata
);
  import eaf_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    push, full, head_valid, pop;
  entry_t  wr_entry, head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE_MASK: cfg_nxt.enable_mask      = cfg_wdata[MASK_W-1:0];
        CFG_STEP_MIN:    cfg_nxt.step_min         = cfg_wdata[THR_W-1:0];
        CFG_ROC_MAX:     cfg_nxt.roc_max          = cfg_wdata[THR_W-1:0];
        CFG_VALUE_LOW:   cfg_nxt.value_low_limit  = $signed(cfg_wdata[VALUE_W-1:0]);
        CFG_VALUE_HIGH:  cfg_nxt.value_high_limit = $signed(cfg_wdata[VALUE_W-1:0]);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = full;

  eaf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .full              (full),
    .in_sample_quality (in_sample_quality),
    .in_sample_value   (in_sample_value),
    .in_sample_time_us (in_sample_time_us),
    .push              (push),
    .entry             (wr_entry)
  );

  eaf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_entry   (wr_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  eaf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .roc_max            (cfg_r.roc_max),
    .head_valid         (head_valid),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_archive_now    (out_archive_now),
    .out_exception_kind (out_exception_kind)
  );

endmodule
